// ===== design/frequency_table_header_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frequency table header parser
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_TABLE_HEADER_PARSER_MACROS_SVH
`define FREQUENCY_TABLE_HEADER_PARSER_MACROS_SVH

// Same-cycle implication.
`define FTHP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication.
`define FTHP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== design/fthp_pkg.sv =====
// ----------------------------------------------------------------------------
// fthp_pkg
// Types, constants and helpers shared by the header parser modules.
// ----------------------------------------------------------------------------
package fthp_pkg;

	localparam logic [7:0] KEY_XOR      = 8'h80;
	localparam logic [8:0] LIST_ENTRIES = 9'd256;

	localparam logic [1:0] WSEL_ONE = 2'b00;
	localparam logic [1:0] WSEL_TWO = 2'b01;

	typedef struct packed {
		logic [7:0]  symbol;
		logic [31:0] weight;
		logic        entry_valid;
		logic        header_done;
		logic [10:0] header_bytes;
	} res_t;

	// Number of bytes per weight from flag bits 2:1.
	function automatic logic [2:0] value_bytes_of(input logic [1:0] wsel);
		logic [2:0] n;
		unique case (wsel)
			WSEL_ONE: n = 3'd1;
			WSEL_TWO: n = 3'd2;
			default:  n = 3'd4;
		endcase
		return n;
	endfunction

endpackage

// ===== design/fthp_byte_if.sv =====
// ----------------------------------------------------------------------------
// fthp_byte_if
// Valid/ready channel carrying one raw header byte per item.
// ----------------------------------------------------------------------------
interface fthp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ===== design/fthp_entry_if.sv =====
// ----------------------------------------------------------------------------
// fthp_entry_if
// Valid/ready channel carrying one decoded table entry per item.
// ----------------------------------------------------------------------------
interface fthp_entry_if;
	logic        valid;
	logic        ready;
	logic [7:0]  symbol;
	logic [31:0] weight;
	logic        entry_valid;
	logic        header_done;
	logic [10:0] header_bytes;

	modport source (
		output valid, output symbol, output weight, output entry_valid,
		output header_done, output header_bytes, input ready
	);
	modport sink (
		input valid, input symbol, input weight, input entry_valid,
		input header_done, input header_bytes, output ready
	);
endinterface

// ===== design/fthp_in_reg.sv =====
// ----------------------------------------------------------------------------
// fthp_in_reg
// Input register stage holding one header byte for the parser.
// ----------------------------------------------------------------------------
module fthp_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	output logic       in_ready,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

// ===== design/fthp_parser.sv =====
// ----------------------------------------------------------------------------
// fthp_parser
// Header state machine: consumes one byte per step and forms the result.
// ----------------------------------------------------------------------------
`include "frequency_table_header_parser_macros.svh"

module fthp_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          order,
	input  logic          step,
	input  logic [7:0]    data_byte,
	output logic          res_valid,
	output fthp_pkg::res_t res
);

	localparam logic [1:0] PH_FLAG  = 2'd0;
	localparam logic [1:0] PH_COUNT = 2'd1;
	localparam logic [1:0] PH_KEY   = 2'd2;
	localparam logic [1:0] PH_VALUE = 2'd3;

	logic [1:0]  phase_q, phase_n;
	logic        list_q, list_n;
	logic [2:0]  vbytes_q, vbytes_n;
	logic [8:0]  left_q, left_n;
	logic [1:0]  biv_q, biv_n;
	logic [31:0] acc_q, acc_n;
	logic [7:0]  sym_q, sym_n;
	logic [10:0] bytes_q, bytes_n;

	logic [2:0]  count;
	logic [31:0] acc_shift;
	logic [10:0] bytes_inc;
	logic        done;

	always_comb begin
		count     = {1'b0, biv_q} + 3'd1;
		acc_shift = order ? (acc_q | ({24'b0, data_byte} << {biv_q, 3'b000}))
		                  : {acc_q[23:0], data_byte};
		bytes_inc = bytes_q + 11'd1;
		done      = (left_q == 9'd1);

		phase_n   = phase_q;
		list_n    = list_q;
		vbytes_n  = vbytes_q;
		left_n    = left_q;
		biv_n     = biv_q;
		acc_n     = acc_q;
		sym_n     = sym_q;
		bytes_n   = bytes_q;
		res_valid = 1'b0;
		res       = '0;

		unique case (phase_q)
			PH_FLAG: begin
				list_n   = data_byte[0];
				vbytes_n = fthp_pkg::value_bytes_of(data_byte[2:1]);
				bytes_n  = 11'd1;
				acc_n    = '0;
				biv_n    = '0;
				sym_n    = '0;
				if (data_byte[0]) begin
					left_n  = fthp_pkg::LIST_ENTRIES;
					phase_n = PH_VALUE;
				end else begin
					left_n  = '0;
					phase_n = PH_COUNT;
				end
			end
			PH_COUNT: begin
				bytes_n = bytes_inc;
				if (data_byte == 8'd0) begin
					phase_n          = PH_FLAG;
					res_valid        = 1'b1;
					res.header_done  = 1'b1;
					res.header_bytes = bytes_inc;
				end else begin
					left_n  = {1'b0, data_byte};
					phase_n = PH_KEY;
				end
			end
			PH_KEY: begin
				bytes_n = bytes_inc;
				sym_n   = data_byte ^ fthp_pkg::KEY_XOR;
				acc_n   = '0;
				biv_n   = '0;
				phase_n = PH_VALUE;
			end
			PH_VALUE: begin
				bytes_n = bytes_inc;
				if (count < vbytes_q) begin
					acc_n = acc_shift;
					biv_n = count[1:0];
				end else begin
					acc_n            = '0;
					biv_n            = '0;
					left_n           = left_q - 9'd1;
					sym_n            = list_q ? sym_q + 8'd1 : sym_q;
					phase_n          = done ? PH_FLAG : (list_q ? PH_VALUE : PH_KEY);
					res_valid        = 1'b1;
					res.symbol       = sym_q;
					res.weight       = acc_shift;
					res.entry_valid  = 1'b1;
					res.header_done  = done;
					res.header_bytes = done ? bytes_inc : 11'd0;
				end
			end
			default: begin
				phase_n = PH_FLAG;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FLAG;
			list_q   <= 1'b0;
			vbytes_q <= 3'd1;
			left_q   <= '0;
			biv_q    <= '0;
			acc_q    <= '0;
			sym_q    <= '0;
			bytes_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			list_q   <= list_n;
			vbytes_q <= vbytes_n;
			left_q   <= left_n;
			biv_q    <= biv_n;
			acc_q    <= acc_n;
			sym_q    <= sym_n;
			bytes_q  <= bytes_n;
		end
	end

	`FTHP_ASSERT_NEXT(a_done_returns_to_flag, step && res_valid && res.header_done,
		phase_q == PH_FLAG, "header end did not return to flag phase")
	`FTHP_ASSERT_NOW(a_empty_only_at_end, res_valid && !res.entry_valid,
		res.header_done, "entry-less result that does not end the header")
	`FTHP_ASSERT_NOW(a_byte_index_in_range, phase_q == PH_VALUE,
		{1'b0, biv_q} < vbytes_q, "weight byte index beyond weight width")

endmodule

// ===== design/fthp_out_reg.sv =====
// ----------------------------------------------------------------------------
// fthp_out_reg
// Result register that holds a finished item until the receiver takes it.
// ----------------------------------------------------------------------------
module fthp_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  fthp_pkg::res_t res_in,
	input  logic           out_ready,
	output logic           out_valid,
	output fthp_pkg::res_t res_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// ===== design/frequency_table_header_parser.sv =====
// ----------------------------------------------------------------------------
// frequency_table_header_parser
// Decodes a frequency table header byte by byte into symbol/weight items.
// ----------------------------------------------------------------------------
// The stream channel takes one header byte per item; the entries channel
// gives one item per decoded table entry, and one entry-less item with
// header_done set for an empty dictionary. The item that ends a header
// carries header_done and the header length in bytes, flag byte included.
// cfg_we/cfg_wdata write weight_byte_order (0: most significant byte first,
// 1: least significant byte first); it should only change while idle.
// A byte sits in the input register and is parsed into the result register
// once the result register is empty or being drained, and the result is
// offered to the receiver from there. The state update lets one byte be
// taken every cycle, sustained while the receiver keeps entries.ready high.
// When the receiver stalls, the result register holds its item; the input
// register takes at most one more byte, after which stream.ready falls.
// Bytes that complete no entry pass through without waiting on the receiver
// only when the result register is free to move.
// Reset returns the parser to waiting for a flag byte, empties both
// registers and sets the byte order to most significant byte first.
// ----------------------------------------------------------------------------
module frequency_table_header_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	fthp_byte_if.sink    stream,
	fthp_entry_if.source entries
);

	logic           order_q;
	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           advance;
	logic           step;
	logic           res_valid;
	fthp_pkg::res_t res;
	fthp_pkg::res_t res_q;

	// The byte order register; the user must write it only between headers, as the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_we) begin
			order_q <= cfg_wdata;
		end
	end

	// The parser may move whenever the result register is empty or being
	// drained this cycle.
	assign advance = !entries.valid || entries.ready;
	assign step    = valid_s1 && advance;

	fthp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stream.valid),
		.in_byte  (stream.data_byte),
		.in_ready (stream.ready),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	fthp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.order     (order_q),
		.step      (step),
		.data_byte (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	fthp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && res_valid),
		.res_in    (res),
		.out_ready (entries.ready),
		.out_valid (entries.valid),
		.res_q     (res_q)
	);

	assign entries.symbol       = res_q.symbol;
	assign entries.weight       = res_q.weight;
	assign entries.entry_valid  = res_q.entry_valid;
	assign entries.header_done  = res_q.header_done;
	assign entries.header_bytes = res_q.header_bytes;

endmodule
